FILE: rtl/rsc_pkg.sv
// rsc_pkg: shared types, opcodes and constants for the RPN stack calculator.
// No dependencies; imported by every rtl module.
package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VAR_COUNT_DEF   = 26;

    localparam int DATA_W      = 32;
    localparam int KIND_W      = 4;
    localparam int VIDX_W      = 5;
    localparam int ERR_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int DIV_DVD_W   = 48;
    localparam int FRAC_W      = 16;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_PUSH        = 4'd0;
    localparam t_kind K_POP         = 4'd1;
    localparam t_kind K_PEEK        = 4'd2;
    localparam t_kind K_DUP         = 4'd3;
    localparam t_kind K_SWAP        = 4'd4;
    localparam t_kind K_CLEAR       = 4'd5;
    localparam t_kind K_ADD         = 4'd6;
    localparam t_kind K_SUB         = 4'd7;
    localparam t_kind K_MUL         = 4'd8;
    localparam t_kind K_DIV         = 4'd9;
    localparam t_kind K_MOD         = 4'd10;
    localparam t_kind K_RECALL_LAST = 4'd11;
    localparam t_kind K_RECALL_VAR  = 4'd12;
    localparam t_kind K_STORE       = 4'd13;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_UNDER = 3'd1,
        ERR_OVER  = 3'd2,
        ERR_DIV0  = 3'd3,
        ERR_MOD0  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        PS_OPND,
        PS_B,
        PS_A,
        PS_RES,
        PS_LAST,
        PS_VAR
    } t_push_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD1,
        S_TK1,
        S_RD2,
        S_TK2,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_ALU,
        S_PUSH1,
        S_PUSH2,
        S_STVAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load;
        logic      rd;
        logic      take_b;
        logic      take_a;
        logic      push;
        t_push_src push_src;
        logic      clear;
        logic      mul;
        logic      div_start;
        logic      alu;
        logic      raise;
        t_err      raise_code;
        logic      store_var;
        logic      finish;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  take_zero;
        logic  var_ok;
        logic  prev_ok;
        logic  div_done;
        logic  out_free;
    } t_dp_sts;

endpackage

FILE: rtl/rsc_div.sv
// rsc_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rsc_pkg.
module rsc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rsc_pkg::DIV_DVD_W-1:0]  i_dividend,
    input  logic [rsc_pkg::DATA_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [rsc_pkg::DIV_DVD_W-1:0]  o_quot,
    output logic [rsc_pkg::DATA_W-1:0]     o_rem
);
    import rsc_pkg::*;

    localparam int CW = $clog2(DIV_DVD_W + 1);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DVD_W-1:0] r_q;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W-1:0]    r_den;
    logic [DATA_W:0]      rem_sh;
    logic                 ge;

    assign rem_sh = {r_rem[DATA_W-1:0], r_q[DIV_DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_DVD_W-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem[DATA_W-1:0];

endmodule

FILE: rtl/rsc_datapath.sv
// rsc_datapath: stack memory, variables, operand registers, ALU and output word.
// Depends on rsc_pkg and rsc_div.
module rsc_datapath #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = rsc_pkg::VAR_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rsc_pkg::t_dp_cmd             i_cmd,
    output rsc_pkg::t_dp_sts             o_sts,
    input  logic [rsc_pkg::KIND_W-1:0]   i_kind,
    input  logic [rsc_pkg::DATA_W-1:0]   i_opnd,
    input  logic [rsc_pkg::VIDX_W-1:0]   i_vidx,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rsc_pkg::DATA_W-1:0]   o_shown_value,
    output logic                         o_shown_valid,
    output logic [rsc_pkg::ERR_W-1:0]    o_error_code
);
    import rsc_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    logic [DATA_W-1:0]        r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]        r_rdata;
    logic [SPW-1:0]           r_sp;
    logic [DATA_W-1:0]        r_vars [VAR_COUNT];
    t_kind                    r_kind;
    logic [DATA_W-1:0]        r_opnd;
    logic [VIDX_W-1:0]        r_vidx;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic [DATA_W-1:0]        r_res;
    logic signed [63:0]       r_prod;
    t_err                     r_err;
    t_err                     n_err;
    logic [DATA_W-1:0]        r_last;
    logic                     r_prev_rec;
    logic [VIDX_W-1:0]        r_prev_idx;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_shown;
    t_err                     r_out_err;

    logic                     sp_empty;
    logic                     sp_full;
    logic [DATA_W-1:0]        take_val;
    logic                     var_ok;
    logic [DATA_W-1:0]        var_val;
    logic [DATA_W-1:0]        push_val;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        ua;
    logic [DATA_W-1:0]        ub;
    logic [DIV_DVD_W-1:0]     dvd;
    logic                     div_done;
    logic [DIV_DVD_W-1:0]     quot;
    logic [DATA_W-1:0]        rem;
    logic signed [63:0]       prod_adj;
    logic signed [63:0]       qmag;
    logic signed [DATA_W:0]   sum;
    logic [DATA_W-1:0]        alu_val;
    logic                     shown;

    function automatic logic [DATA_W-1:0] sat64(input logic signed [63:0] v);
        if (!v[63] && (v[62:DATA_W-1] != '0)) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v[63] && !(&v[62:DATA_W-1])) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    assign sp_empty = (r_sp == '0);
    assign sp_full  = (r_sp >= SPW'(STACK_DEPTH));
    assign take_val = sp_empty ? '0 : r_rdata;
    assign var_ok   = (r_vidx < VIDX_W'(VAR_COUNT));
    assign var_val  = r_vars[r_vidx[VW-1:0]];
    assign rd_addr  = AW'(r_sp - 1'b1);
    assign shown    = (r_kind == K_POP) || (r_kind == K_PEEK);

    always_comb begin
        case (i_cmd.push_src)
            PS_OPND: push_val = r_opnd;
            PS_B:    push_val = r_b;
            PS_A:    push_val = r_a;
            PS_RES:  push_val = r_res;
            PS_LAST: push_val = r_last;
            PS_VAR:  push_val = var_val;
            default: push_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !sp_full) begin
            r_mem[r_sp[AW-1:0]] <= push_val;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.clear) begin
            r_sp <= '0;
        end else if ((i_cmd.take_a || i_cmd.take_b) && !sp_empty) begin
            r_sp <= r_sp - 1'b1;
        end else if (i_cmd.push && !sp_full) begin
            r_sp <= r_sp + 1'b1;
        end
    end

    always_comb begin
        n_err = r_err;
        if (r_err == ERR_NONE) begin
            if ((i_cmd.take_a || i_cmd.take_b) && sp_empty) begin
                n_err = ERR_UNDER;
            end else if (i_cmd.push && sp_full) begin
                n_err = ERR_OVER;
            end else if (i_cmd.raise) begin
                n_err = i_cmd.raise_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= ERR_NONE;
        end else if (i_cmd.load) begin
            r_err <= ERR_NONE;
        end else begin
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_opnd <= i_opnd;
            r_vidx <= i_vidx;
        end
        if (i_cmd.take_b) begin
            r_b <= take_val;
        end
        if (i_cmd.take_a) begin
            r_a <= take_val;
        end
        if (i_cmd.mul) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.alu) begin
            r_res <= alu_val;
        end
    end

    // divider works on magnitudes
    assign ua  = r_a[DATA_W-1] ? DATA_W'(-r_a) : r_a;
    assign ub  = r_b[DATA_W-1] ? DATA_W'(-r_b) : r_b;
    assign dvd = (r_kind == K_DIV) ? {ua, {FRAC_W{1'b0}}} : {{FRAC_W{1'b0}}, ua};

    rsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (ub),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign prod_adj = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);
    assign qmag     = $signed({16'b0, quot});
    assign sum      = (r_kind == K_SUB) ? ({r_a[DATA_W-1], r_a} - {r_b[DATA_W-1], r_b})
                                        : ({r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b});

    always_comb begin
        case (r_kind)
            K_ADD, K_SUB: alu_val = sat64(64'(sum));
            K_MUL:        alu_val = sat64(prod_adj >>> FRAC_W);
            K_DIV:        alu_val = sat64((r_a[DATA_W-1] ^ r_b[DATA_W-1]) ? -qmag : qmag);
            K_MOD:        alu_val = r_a[DATA_W-1] ? DATA_W'(-rem) : rem;
            default:      alu_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_prev_rec <= 1'b0;
            r_prev_idx <= '0;
            for (int i = 0; i < VAR_COUNT; i++) begin
                r_vars[i] <= '0;
            end
        end else begin
            if (i_cmd.store_var) begin
                r_vars[r_prev_idx[VW-1:0]] <= r_a;
            end
            if (i_cmd.finish) begin
                if (r_kind == K_POP) begin
                    r_last <= r_b;
                end
                r_prev_rec <= (r_kind == K_RECALL_VAR) && var_ok;
                if ((r_kind == K_RECALL_VAR) && var_ok) begin
                    r_prev_idx <= r_vidx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= shown ? r_b : '0;
            r_out_shown <= shown;
            r_out_err   <= r_err;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.take_zero = (take_val == '0);
    assign o_sts.var_ok    = var_ok;
    assign o_sts.prev_ok   = r_prev_rec;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_shown_value = r_out_value;
    assign o_shown_valid = r_out_shown;
    assign o_error_code  = r_out_err;

endmodule

FILE: rtl/rsc_ctrl.sv
// rsc_ctrl: token sequencer; steps the datapath through pops, ALU and pushes.
// Depends on rsc_pkg.
module rsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rsc_pkg::t_dp_sts i_sts,
    output rsc_pkg::t_dp_cmd o_cmd
);
    import rsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_sts.kind) inside
                    K_PUSH, K_RECALL_LAST:       n_state = S_PUSH1;
                    K_RECALL_VAR:                n_state = i_sts.var_ok ? S_PUSH1 : S_DONE;
                    [K_POP:K_SWAP], [K_ADD:K_MOD], K_STORE: n_state = S_RD1;
                    default:                     n_state = S_DONE;
                endcase
            end
            S_RD1: n_state = S_TK1;
            S_TK1: begin
                case (i_sts.kind) inside
                    K_POP:        n_state = S_DONE;
                    K_PEEK, K_DUP: n_state = S_PUSH1;
                    K_DIV, K_MOD: n_state = i_sts.take_zero ? S_DONE : S_RD2;
                    K_STORE:      n_state = i_sts.prev_ok ? S_RD2 : S_DONE;
                    default:      n_state = S_RD2;
                endcase
            end
            S_RD2: n_state = S_TK2;
            S_TK2: begin
                case (i_sts.kind) inside
                    K_SWAP:       n_state = S_PUSH1;
                    K_ADD, K_SUB: n_state = S_ALU;
                    K_MUL:        n_state = S_MUL;
                    K_DIV, K_MOD: n_state = S_DIVS;
                    K_STORE:      n_state = S_STVAR;
                    default:      n_state = S_DONE;
                endcase
            end
            S_MUL:  n_state = S_ALU;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (i_sts.div_done) n_state = S_ALU;
            end
            S_ALU:  n_state = S_PUSH1;
            S_PUSH1: begin
                n_state = ((i_sts.kind == K_DUP) || (i_sts.kind == K_SWAP)) ? S_PUSH2 : S_DONE;
            end
            S_PUSH2: n_state = S_DONE;
            S_STVAR: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.push_src   = PS_OPND;
        o_cmd.raise_code = ERR_NONE;
        o_in_ready       = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:  o_cmd.load = i_in_valid;
            S_EXEC:  o_cmd.clear = (i_sts.kind == K_CLEAR);
            S_RD1:   o_cmd.rd = 1'b1;
            S_TK1: begin
                o_cmd.take_b = 1'b1;
                if (i_sts.take_zero && (i_sts.kind == K_DIV)) begin
                    o_cmd.raise      = 1'b1;
                    o_cmd.raise_code = ERR_DIV0;
                end else if (i_sts.take_zero && (i_sts.kind == K_MOD)) begin
                    o_cmd.raise      = 1'b1;
                    o_cmd.raise_code = ERR_MOD0;
                end
            end
            S_RD2:   o_cmd.rd = 1'b1;
            S_TK2:   o_cmd.take_a = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_DIVS:  o_cmd.div_start = 1'b1;
            S_ALU:   o_cmd.alu = 1'b1;
            S_PUSH1: begin
                o_cmd.push = 1'b1;
                case (i_sts.kind) inside
                    K_PUSH:                 o_cmd.push_src = PS_OPND;
                    K_RECALL_LAST:          o_cmd.push_src = PS_LAST;
                    K_RECALL_VAR:           o_cmd.push_src = PS_VAR;
                    K_PEEK, K_DUP, K_SWAP:  o_cmd.push_src = PS_B;
                    default:                o_cmd.push_src = PS_RES;
                endcase
            end
            S_PUSH2: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_src = (i_sts.kind == K_SWAP) ? PS_A : PS_B;
            end
            S_STVAR: o_cmd.store_var = 1'b1;
            S_DONE:  o_cmd.finish = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/rpn_stack_calculator_top.sv
// rpn_stack_calculator_top: RPN stack calculator, one token word in, one result word out.
// Depends on rsc_pkg, rsc_ctrl, rsc_datapath.
//
//  Channel  Dir  tdata (low bit up)                          tuser
//  s_axis   in   operand_value[31:0], var_index[36:32]       req_type[3:0]
//  m_axis   out  shown_value[31:0], error_code[34:32]        shown_valid[0]
//
// One token at a time; div and mod also run through the 48-step bit-serial divider.
// Stack memory is read one entry per cycle through a registered read port.
// Reset clears stack pointer, variables, last printed value and recall note.
// A waiting result word holds in its register; the token after it stalls only at its end.
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = rsc_pkg::VAR_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rsc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // operand_value, var_index
    input  logic [rsc_pkg::KIND_W-1:0]        i_s_axis_tuser,  // req_type
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rsc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // shown_value, error_code
    output logic [0:0]                        o_m_axis_tuser   // shown_valid
);
    import rsc_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [DATA_W-1:0] shown_value;
    logic              shown_valid;
    logic [ERR_W-1:0]  error_code;

    rsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_COUNT   (VAR_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_s_axis_tuser),
        .i_opnd        (i_s_axis_tdata[DATA_W-1:0]),
        .i_vidx        (i_s_axis_tdata[DATA_W+VIDX_W-1:DATA_W]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_shown_value (shown_value),
        .o_shown_valid (shown_valid),
        .o_error_code  (error_code)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-DATA_W-ERR_W){1'b0}}, error_code, shown_value};
    assign o_m_axis_tuser = shown_valid;

endmodule

FILE: rtl/rsc_checker.sv
// rsc_checker: port-level assertions for the calculator top, bound to it below.
// Depends on rsc_pkg and rpn_stack_calculator_top.
module rsc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [rsc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [0:0]                        o_m_axis_tuser
);
    import rsc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[DATA_W+ERR_W-1:DATA_W] <= 3'(ERR_MOD0)))
        else $error("error code out of range");

    a_zero_unshown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> (o_m_axis_tdata[DATA_W-1:0] == '0))
        else $error("nonzero value on unprinted result");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second token taken while busy");

endmodule

bind rpn_stack_calculator_top rsc_checker u_rsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/sv/rpn_stack_calculator_checker.sv
`timescale 1ns / 1ps
// rpn_stack_calculator_checker: watches both streams of the RPN calculator, models the
// stack machine per accepted token word and compares every result word. Depends on rsc_pkg.
module rpn_stack_calculator_checker #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = rsc_pkg::VAR_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [rsc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [rsc_pkg::KIND_W-1:0]      i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [rsc_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [0:0]                      i_m_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rsc_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] shown;
        logic              shown_ok;
        t_err              err;
    } t_result;

    logic signed [DATA_W-1:0] stk [STACK_DEPTH];
    logic signed [DATA_W-1:0] vars [VAR_COUNT];
    int                       sp;
    logic signed [DATA_W-1:0] last_shown;
    logic                     recalled;
    logic [VIDX_W-1:0]        recall_idx;
    t_err                     tok_err;
    t_result                  results_due[$];

    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic void flag(input t_err e);
        if (tok_err == ERR_NONE) tok_err = e;
    endfunction

    function automatic logic signed [DATA_W-1:0] pop_val();
        if (sp == 0) begin
            flag(ERR_UNDER);
            return '0;
        end
        sp--;
        return stk[sp];
    endfunction

    function automatic void push_val(input logic signed [DATA_W-1:0] v);
        if (sp >= STACK_DEPTH) begin
            flag(ERR_OVER);
            return;
        end
        stk[sp] = v;
        sp++;
    endfunction

    function automatic t_result exec_token(input t_kind k, input logic signed [DATA_W-1:0] opnd,
                                           input logic [VIDX_W-1:0] vi);
        logic signed [DATA_W-1:0] a, b, shown;
        logic signed [63:0]       w;
        logic                     ok, now_recall;
        t_result                  r;
        shown = '0;
        ok = 1'b0;
        now_recall = 1'b0;
        tok_err = ERR_NONE;
        case (k)
            K_PUSH: push_val(opnd);
            K_POP: begin
                shown = pop_val();
                ok = 1'b1;
                last_shown = shown;
            end
            K_PEEK: begin
                shown = pop_val();
                ok = 1'b1;
                push_val(shown);
            end
            K_DUP: begin
                a = pop_val();
                push_val(a);
                push_val(a);
            end
            K_SWAP: begin
                b = pop_val();
                a = pop_val();
                push_val(b);
                push_val(a);
            end
            K_CLEAR: sp = 0;
            K_ADD, K_SUB, K_MUL: begin
                b = pop_val();
                a = pop_val();
                if (k == K_ADD) w = 64'(a) + 64'(b);
                else if (k == K_SUB) w = 64'(a) - 64'(b);
                else w = (64'(a) * 64'(b)) / 64'sd65536;
                push_val(clamp(w));
            end
            K_DIV, K_MOD: begin
                b = pop_val();
                if (b == 0) begin
                    flag(k == K_DIV ? ERR_DIV0 : ERR_MOD0);
                end else begin
                    a = pop_val();
                    if (k == K_DIV) push_val(clamp((64'(a) * 64'sd65536) / 64'(b)));
                    else push_val(clamp(64'(a) % 64'(b)));
                end
            end
            K_RECALL_LAST: push_val(last_shown);
            K_RECALL_VAR: begin
                if (vi < VAR_COUNT) begin
                    push_val(vars[vi]);
                    now_recall = 1'b1;
                end
            end
            K_STORE: begin
                a = pop_val();
                if (recalled && recall_idx < VAR_COUNT) vars[recall_idx] = pop_val();
            end
            default: ;
        endcase
        recalled = now_recall;
        if (now_recall) recall_idx = vi;
        r.shown = shown;
        r.shown_ok = ok;
        r.err = tok_err;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            sp = 0;
            last_shown = '0;
            recalled = 1'b0;
            recall_idx = '0;
            foreach (vars[i]) vars[i] = '0;
            results_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(exec_token(t_kind'(i_s_tuser), i_s_tdata[31:0],
                                                 i_s_tdata[36:32]));
            if (i_m_tvalid && i_m_tready) begin
                got.shown = i_m_tdata[31:0];
                got.err = t_err'(i_m_tdata[34:32]);
                got.shown_ok = i_m_tuser[0];
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want || i_m_tdata[39:35] !== '0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp value %h valid %b err %0d, got %h %b %0d",
                                     want.shown, want.shown_ok, want.err,
                                     got.shown, got.shown_ok, got.err);
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

FILE: tb/sv/rpn_stack_calculator_top_tb.sv
`timescale 1ns / 1ps
// rpn_stack_calculator_top_tb: drives directed and random token words into the RPN
// calculator with random gaps and stalls; depends on rsc_pkg and the checker module.
module rpn_stack_calculator_top_tb;
    import rsc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    int                     fail_count, pending, idle_cycles;
    logic                   rx_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    rpn_stack_calculator_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    rpn_stack_calculator_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            n = gap_len();
            if (n == 0) begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send(input t_kind k, input logic [31:0] v, input logic [4:0] vi,
                        input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {3'b0, vi, v};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 8) << 16;
            4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int k;
        t_kind op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty-stack cases, saturation, zero divisors, store via recall
        send(K_POP, 0, 0, 0);
        send(K_PEEK, 0, 0, 0);
        send(K_DUP, 0, 0, 0);
        send(K_CLEAR, 0, 0, 0);
        send(K_ADD, 0, 0, 0);
        send(K_PUSH, 32'h7FFF_FFFF, 5'h1F, 0);
        send(K_PUSH, 32'h7FFF_FFFF, 0, 0);
        send(K_ADD, 0, 0, 0);
        send(K_PUSH, 32'h8000_0000, 0, 0);
        send(K_MUL, 0, 0, 0);
        send(K_PUSH, 32'h0, 0, 0);
        send(K_DIV, 0, 0, 0);
        send(K_PUSH, 32'h0, 0, 0);
        send(K_MOD, 0, 0, 0);
        send(K_PUSH, 32'hFFFF_8000, 0, 0);
        send(K_SWAP, 0, 0, 0);
        send(K_SUB, 0, 0, 0);
        send(K_POP, 0, 0, 0);
        send(K_RECALL_LAST, 0, 0, 0);
        send(K_RECALL_VAR, 0, 25, 0);
        send(K_STORE, 0, 0, 0);
        send(K_RECALL_VAR, 0, 25, 0);
        send(K_RECALL_VAR, 0, 26, 0);
        send(K_STORE, 0, 0, 0);
        send(4'd15, 32'hFFFF_FFFF, 5'h1F, 0);
        drain();
        // fill past the top while the receiver holds off
        rx_hold = 1'b1;
        for (int i = 0; i < 132; i++) send(K_PUSH, rand_val(), 0, 0);
        send(K_CLEAR, 0, 0, 0);
        drain();
        for (int i = 0; i < 330; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20) op = K_PUSH;
            else if (k < 90) op = t_kind'($urandom_range(1, 13));
            else if (k < 95) op = K_RECALL_VAR;
            else op = t_kind'($urandom_range(14, 15));
            if (op == K_RECALL_VAR && $urandom_range(0, 1)) begin
                send(K_PUSH, rand_val(), 5'($urandom), 1);
                send(K_RECALL_VAR, $urandom, 5'($urandom_range(0, 27)), 1);
                op = K_STORE;
            end
            if (op == K_CLEAR && $urandom_range(0, 3) != 0) op = K_DUP;
            send(op, rand_val(),
                 (op == K_RECALL_VAR) ? 5'($urandom_range(0, 27)) : 5'($urandom), 1);
            if (i == 160) drain();
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
